// ----- hdl/damped_spring_force_core_defines.svh -----
// Assertion macros shared by the damped spring force RTL.
// Needs clk and rst_n in the scope of each use; SYNTH removes the checks.
`ifndef DAMPED_SPRING_FORCE_CORE_DEFINES_SVH
`define DAMPED_SPRING_FORCE_CORE_DEFINES_SVH
`ifndef SYNTH
`define DSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DSF_ASSERT_IMP(lbl, ante, cons, msg)
`define DSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/dsf_pkg.sv -----
// Package for the damped spring force core: number format, stage map and the
// per-stage payload type. Used by damped_spring_force_core.
`timescale 1ns / 1ps
package dsf_pkg;
    localparam int FRAC_BITS = 16;
    localparam int UNIT_BITS = 29;
    localparam int ROOT_BITS = 34;
    localparam int QUO_BITS  = 30;

    localparam int ST_DIFF  = 0;
    localparam int ST_SQR   = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_ROOT0 = 3;
    localparam int ST_PREP  = ST_ROOT0 + ROOT_BITS;
    localparam int ST_DIV0  = ST_PREP + 1;
    localparam int ST_PROJ  = ST_DIV0 + QUO_BITS;
    localparam int ST_PSUM  = ST_PROJ + 1;
    localparam int ST_TERM  = ST_PSUM + 1;
    localparam int ST_MUL   = ST_TERM + 1;
    localparam int ST_SCAL  = ST_MUL + 1;
    localparam int ST_FMUL  = ST_SCAL + 1;
    localparam int ST_OUT   = ST_FMUL + 1;
    localparam int NSTG     = ST_OUT + 1;

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_STIFFNESS = 1'b0;
    localparam logic REG_DAMPING   = 1'b1;

    typedef struct packed {
        logic [2:0][32:0] d;
        logic [2:0][31:0] vel;
        logic [30:0]      rest;
        logic [2:0][64:0] sq;
        logic [66:0]      rem;
        logic [33:0]      root;
        logic [2:0][63:0] num;
        logic [33:0]      den;
        logic [2:0][33:0] prem;
        logic [2:0][29:0] quo;
        logic [2:0][62:0] prod;
        logic [64:0]      psum;
        logic             vp_neg;
        logic [33:0]      vp_mag;
        logic             ext_neg;
        logic [33:0]      ext_mag;
        logic [65:0]      pa;
        logic [65:0]      pb;
        logic [31:0]      f;
        logic [2:0][62:0] fp;
        logic [2:0][31:0] frc;
        logic             degen;
    } pipe_t;

    function automatic logic [31:0] sat32(input logic signed [68:0] v);
        if (v > 69'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -69'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [30:0] unit_of(input logic [32:0] d, input logic [29:0] q);
        return d[32] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction
endpackage

// ----- hdl/damped_spring_force_core.sv -----
// Damped spring force core: Hooke spring plus damper along the spring axis.
// Depends on dsf_pkg and damped_spring_force_core_defines.svh.
//
//   channel   dir   beat contents
//   s_axis    in    two endpoints, relative velocity, rest length
//   m_axis    out   force on the first particle, degenerate flag in tuser
//   apb       in    stiffness at 0x0, damping at 0x4
//
// One spring is accepted per cycle unless a stall at m_axis has backed up to the input.
// The pipeline holds the 34-stage square root and the 30-stage divider.
// Reset clears the valid bits, loads stiffness 1.0 and damping 0.
// A stall holds only the stages that are full; bubbles close up behind it.
`timescale 1ns / 1ps
`include "damped_spring_force_core_defines.svh"
module damped_spring_force_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // rel_vel_x, rel_vel_y, rel_vel_z, rest_length, zero pad bit
    input  logic [319:0]                   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // force_x, force_y, force_z
    output logic [95:0]                    m_tdata,
    // degenerate
    output logic                           m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import dsf_pkg::*;

    logic [31:0]     stiffness_reg;
    logic [31:0]     damping_reg;
    pipe_t           stg_reg  [NSTG];
    pipe_t           stg_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic [NSTG-1:0] adv;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DAMPING) ? damping_reg : stiffness_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= 32'd65536;
            damping_reg   <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_STIFFNESS: stiffness_reg <= pwdata;
                REG_DAMPING:   damping_reg   <= pwdata;
                default:       stiffness_reg <= stiffness_reg;
            endcase
        end
    end

    assign adv[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
    assign s_tready    = adv[0];
    assign vld_in      = {vld_reg[NSTG-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= (adv & vld_in) | (~adv & vld_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NSTG; j++)
        begin
            if (adv[j])
                stg_reg[j] <= stg_next[j];
        end
    end

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stage
            if (k < NSTG - 1)
            begin : g_adv
                assign adv[k] = !vld_reg[k] || adv[k+1];
            end

            if (k == ST_DIFF)
            begin : g_diff
                always_comb
                begin
                    stg_next[k] = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        stg_next[k].d[i] = 33'($signed(s_tdata[96+32*i +: 32]))
                                         - 33'($signed(s_tdata[32*i +: 32]));
                        stg_next[k].vel[i] = s_tdata[192+32*i +: 32];
                    end
                    stg_next[k].rest = s_tdata[318:288];
                end
            end
            else if (k == ST_SQR)
            begin : g_sqr
                always_comb
                begin
                    logic [32:0] m;
                    logic [65:0] p;
                    stg_next[k] = stg_reg[k-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        m = stg_reg[k-1].d[i][32] ? 33'(-stg_reg[k-1].d[i]) : stg_reg[k-1].d[i];
                        p = 66'(m) * 66'(m);
                        stg_next[k].sq[i] = p[64:0];
                    end
                end
            end
            else if (k == ST_SUM)
            begin : g_sum
                always_comb
                begin
                    stg_next[k] = stg_reg[k-1];
                    stg_next[k].rem = 67'(stg_reg[k-1].sq[0]) + 67'(stg_reg[k-1].sq[1])
                                    + 67'(stg_reg[k-1].sq[2]);
                    stg_next[k].root = '0;
                end
            end
            else if (k < ST_PREP)
            begin : g_root
                localparam int B = ROOT_BITS - 1 - (k - ST_ROOT0);
                always_comb
                begin
                    logic [67:0] t;
                    stg_next[k] = stg_reg[k-1];
                    t = (68'(stg_reg[k-1].root) << (B + 1)) + (68'(1) << (2 * B));
                    if (t <= 68'(stg_reg[k-1].rem))
                    begin
                        stg_next[k].rem = 67'(68'(stg_reg[k-1].rem) - t);
                        stg_next[k].root[B] = 1'b1;
                    end
                end
            end
            else if (k == ST_PREP)
            begin : g_prep
                always_comb
                begin
                    logic [32:0] m;
                    stg_next[k] = stg_reg[k-1];
                    stg_next[k].degen = (stg_reg[k-1].root == '0);
                    stg_next[k].den = {stg_reg[k-1].root[32:0], 1'b0};
                    for (int i = 0; i < 3; i++)
                    begin
                        m = stg_reg[k-1].d[i][32] ? 33'(-stg_reg[k-1].d[i]) : stg_reg[k-1].d[i];
                        stg_next[k].num[i] = (64'(m) << (UNIT_BITS + 1))
                                           + 64'(stg_reg[k-1].root);
                        stg_next[k].prem[i] = stg_next[k].num[i][63:UNIT_BITS+1];
                        stg_next[k].quo[i] = '0;
                    end
                end
            end
            else if (k < ST_PROJ)
            begin : g_div
                localparam int B = QUO_BITS - 1 - (k - ST_DIV0);
                always_comb
                begin
                    logic [34:0] t;
                    stg_next[k] = stg_reg[k-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        t = {stg_reg[k-1].prem[i], stg_reg[k-1].num[i][B]};
                        if (t >= {1'b0, stg_reg[k-1].den})
                        begin
                            stg_next[k].prem[i] = 34'(t - {1'b0, stg_reg[k-1].den});
                            stg_next[k].quo[i][B] = 1'b1;
                        end
                        else
                            stg_next[k].prem[i] = t[33:0];
                    end
                end
            end
            else if (k == ST_PROJ)
            begin : g_proj
                always_comb
                begin
                    logic signed [30:0] n;
                    logic signed [62:0] p;
                    stg_next[k] = stg_reg[k-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        n = unit_of(stg_reg[k-1].d[i], stg_reg[k-1].quo[i]);
                        p = n * $signed(stg_reg[k-1].vel[i]);
                        stg_next[k].prod[i] = p;
                    end
                end
            end
            else if (k == ST_PSUM)
            begin : g_psum
                always_comb
                begin
                    stg_next[k] = stg_reg[k-1];
                    stg_next[k].psum = 65'($signed(stg_reg[k-1].prod[0]))
                                     + 65'($signed(stg_reg[k-1].prod[1]))
                                     + 65'($signed(stg_reg[k-1].prod[2]));
                end
            end
            else if (k == ST_TERM)
            begin : g_term
                always_comb
                begin
                    logic [64:0] mag;
                    logic [65:0] rnd;
                    logic [34:0] ext;
                    stg_next[k] = stg_reg[k-1];
                    mag = stg_reg[k-1].psum[64] ? 65'(-stg_reg[k-1].psum) : stg_reg[k-1].psum;
                    rnd = 66'(mag) + (66'(1) << (UNIT_BITS - 1));
                    stg_next[k].vp_mag = 34'(rnd >> UNIT_BITS);
                    stg_next[k].vp_neg = stg_reg[k-1].psum[64];
                    ext = {1'b0, stg_reg[k-1].root} - 35'(stg_reg[k-1].rest);
                    stg_next[k].ext_neg = ext[34];
                    stg_next[k].ext_mag = ext[34] ? 34'(-ext) : ext[33:0];
                end
            end
            else if (k == ST_MUL)
            begin : g_mul
                always_comb
                begin
                    stg_next[k] = stg_reg[k-1];
                    stg_next[k].pa = 66'(stiffness_reg) * 66'(stg_reg[k-1].ext_mag);
                    stg_next[k].pb = 66'(damping_reg) * 66'(stg_reg[k-1].vp_mag);
                end
            end
            else if (k == ST_SCAL)
            begin : g_scal
                always_comb
                begin
                    logic [66:0] ra;
                    logic [66:0] rb;
                    logic signed [68:0] sa;
                    logic signed [68:0] sb;
                    stg_next[k] = stg_reg[k-1];
                    ra = (67'(stg_reg[k-1].pa) + (67'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
                    rb = (67'(stg_reg[k-1].pb) + (67'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
                    sa = stg_reg[k-1].ext_neg ? -$signed({2'b0, ra}) : $signed({2'b0, ra});
                    sb = stg_reg[k-1].vp_neg ? -$signed({2'b0, rb}) : $signed({2'b0, rb});
                    stg_next[k].f = sat32(sa - sb);
                end
            end
            else if (k == ST_FMUL)
            begin : g_fmul
                always_comb
                begin
                    logic signed [30:0] n;
                    logic signed [62:0] p;
                    stg_next[k] = stg_reg[k-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        n = unit_of(stg_reg[k-1].d[i], stg_reg[k-1].quo[i]);
                        p = n * $signed(stg_reg[k-1].f);
                        stg_next[k].fp[i] = p;
                    end
                end
            end
            else
            begin : g_out
                always_comb
                begin
                    logic [62:0] mag;
                    logic [63:0] rnd;
                    logic [34:0] q;
                    logic signed [68:0] sv;
                    stg_next[k] = stg_reg[k-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        mag = stg_reg[k-1].fp[i][62] ? 63'(-stg_reg[k-1].fp[i])
                                                     : stg_reg[k-1].fp[i];
                        rnd = 64'(mag) + (64'(1) << (UNIT_BITS - 1));
                        q = 35'(rnd >> UNIT_BITS);
                        sv = stg_reg[k-1].fp[i][62] ? -$signed({34'b0, q})
                                                    : $signed({34'b0, q});
                        stg_next[k].frc[i] = stg_reg[k-1].degen ? 32'd0 : sat32(sv);
                    end
                end
            end
        end
    endgenerate

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {stg_reg[NSTG-1].frc[2], stg_reg[NSTG-1].frc[1], stg_reg[NSTG-1].frc[0]};
    assign m_tuser  = stg_reg[NSTG-1].degen;

    `DSF_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser, m_tdata == 96'd0, "degenerate beat carries a force")
    `DSF_ASSERT_IMP(a_stall_src, !s_tready, vld_reg[NSTG-1] && !m_tready, "input stalled without an output stall")
    `DSF_ASSERT_NXT(a_enter, s_tvalid && s_tready, vld_reg[0], "accepted beat did not enter the pipeline")
endmodule
